// ===== hdl/acdb_pkg.sv =====
package acdb_pkg;

    // Build-time sizing
    localparam int unsigned MAX_PRD_ENTRIES   = 8;
    localparam int unsigned SECTORS_PER_ENTRY = 16;
    localparam int unsigned SLOT_COUNT        = 32;

    // Fixed field widths
    localparam int unsigned CMD_W     = 1;
    localparam int unsigned LBA_W     = 48;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned BUSY_W    = 32;
    localparam int unsigned SLOT_W    = 5;
    localparam int unsigned ENTRY_W   = 4;
    localparam int unsigned OPCODE_W  = 8;
    localparam int unsigned BYTES_W   = 13;

    localparam int unsigned SECTOR_SHIFT = 9;

    // Derived sizes
    localparam int unsigned MAX_SECTORS = MAX_PRD_ENTRIES * SECTORS_PER_ENTRY;
    localparam int unsigned REM_W       = $clog2(MAX_SECTORS + 1);
    localparam int unsigned K_W         = $clog2(MAX_PRD_ENTRIES + 1);
    localparam int unsigned SBYTES_W    = REM_W + SECTOR_SHIFT;

    localparam logic [ADDR_W-1:0] CHUNK_BYTES =
        ADDR_W'(SECTORS_PER_ENTRY) << SECTOR_SHIFT;

    localparam logic [OPCODE_W-1:0] OP_READ_DMA_EXT  = 8'h25;
    localparam logic [OPCODE_W-1:0] OP_WRITE_DMA_EXT = 8'h35;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SLOT  = 2'd1,
        ST_TOO_MANY = 2'd2,
        ST_ZERO     = 2'd3
    } status_t;

    typedef enum logic {
        REC_HEADER = 1'b0,
        REC_PRD    = 1'b1
    } rec_kind_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [LBA_W-1:0]   lba;
        logic [COUNT_W-1:0] sector_count;
        logic [ADDR_W-1:0]  buffer_address;
        logic [BUSY_W-1:0]  busy_slots;
    } request_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic                write_flag;
        logic [ENTRY_W-1:0]  entry_count;
        logic [LBA_W-1:0]    lba;
        logic [COUNT_W-1:0]  count;
        logic [ADDR_W-1:0]   buffer_address;
    } cmd_t;

endpackage

// ===== hdl/acdb_front.sv =====
module acdb_front
    import acdb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  request_t request,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_take
);

    logic     a_valid_reg, a_valid_next;
    request_t a_req_reg;
    logic     b_valid_reg, b_valid_next;
    cmd_t     b_cmd_reg, b_cmd_next;

    logic                a_free, b_free;
    logic                slot_found;
    logic [SLOT_W-1:0]   slot_sel;
    logic [ENTRY_W-1:0]  entries;
    logic [BUSY_W-1:0]   busy;

    // Advance each stage when the one below is free or moving on
    assign b_free    = !b_valid_reg || cmd_take;
    assign a_free    = !a_valid_reg || b_free;
    assign req_stall = !a_free;

    // Lowest free slot among the implemented ones
    always_comb
    begin
        busy       = a_req_reg.busy_slots;
        slot_found = 1'b0;
        slot_sel   = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--)
        begin
            if (!busy[s])
            begin
                slot_found = 1'b1;
                slot_sel   = SLOT_W'(s);
            end
        end
    end

    // Count PRD entries as the number of entry boundaries below the count
    always_comb
    begin
        entries = '0;
        for (int k = 0; k < MAX_PRD_ENTRIES; k++)
        begin
            if (a_req_reg.sector_count > COUNT_W'(k * SECTORS_PER_ENTRY))
            begin
                entries = entries + ENTRY_W'(1);
            end
        end
    end

    // Classify the request and assemble the command
    always_comb
    begin
        b_cmd_next.slot           = slot_sel;
        b_cmd_next.write_flag     = a_req_reg.command[0];
        b_cmd_next.entry_count    = entries;
        b_cmd_next.lba            = a_req_reg.lba;
        b_cmd_next.count          = a_req_reg.sector_count;
        b_cmd_next.buffer_address = a_req_reg.buffer_address;
        if (!slot_found)
        begin
            b_cmd_next.status = ST_NO_SLOT;
        end
        else if (a_req_reg.sector_count == '0)
        begin
            b_cmd_next.status = ST_ZERO;
        end
        else if (a_req_reg.sector_count > COUNT_W'(MAX_SECTORS))
        begin
            b_cmd_next.status = ST_TOO_MANY;
        end
        else
        begin
            b_cmd_next.status = ST_OK;
        end
    end

    // Valid bits travel with the data
    always_comb
    begin
        a_valid_next = a_free ? req_valid : a_valid_reg;
        b_valid_next = b_free ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Hold payload while a stage waits
    always_ff @(posedge clk)
    begin
        if (a_free)
        begin
            a_req_reg <= request;
        end
        if (b_free)
        begin
            b_cmd_reg <= b_cmd_next;
        end
    end

    assign cmd_valid = b_valid_reg;
    assign cmd       = b_cmd_reg;

endmodule

// ===== hdl/acdb_emit.sv =====
module acdb_emit
    import acdb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_take,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [1:0]           status,
    output logic                 record_kind,
    output logic [SLOT_W-1:0]    slot,
    output logic                 write_flag,
    output logic [OPCODE_W-1:0]  ata_opcode,
    output logic [ENTRY_W-1:0]   entry_count,
    output logic [LBA_W-1:0]     lba_out,
    output logic [COUNT_W-1:0]   count_out,
    output logic [ADDR_W-1:0]    entry_address,
    output logic [BYTES_W-1:0]   entry_byte_count,
    output logic                 last
);

    // Sequencer state
    logic               em_valid_reg, em_valid_next;
    cmd_t               em_cmd_reg;
    logic [K_W-1:0]     k_reg, k_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [REM_W-1:0]   rem_reg, rem_next;

    // Output register
    logic                 rsp_valid_reg, rsp_valid_next;
    status_t              status_reg, status_next;
    rec_kind_t            kind_reg, kind_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 write_reg, write_next;
    logic [OPCODE_W-1:0]  opcode_reg, opcode_next;
    logic [ENTRY_W-1:0]   entries_reg, entries_next;
    logic [LBA_W-1:0]     lba_reg, lba_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]    eaddr_reg, eaddr_next;
    logic [BYTES_W-1:0]   ebytes_reg, ebytes_next;
    logic                 last_reg, last_next;

    logic                 out_free, fire, is_ok, rec_last, load;
    logic [REM_W-1:0]     secs;
    logic [SBYTES_W-1:0]  sec_bytes;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign fire     = em_valid_reg && out_free;
    assign is_ok    = (em_cmd_reg.status == ST_OK);
    assign rec_last = !is_ok || (k_reg == em_cmd_reg.entry_count[K_W-1:0]);
    assign cmd_take = !em_valid_reg || (fire && rec_last);
    assign load     = cmd_take && cmd_valid;

    // Size of the current PRD entry: full chunk, or what remains on the last one
    assign secs      = rec_last ? rem_reg : REM_W'(SECTORS_PER_ENTRY);
    assign sec_bytes = {secs, {SECTOR_SHIFT{1'b0}}} - SBYTES_W'(1);

    // Step through header and entries; take the next command on the last record
    always_comb
    begin
        em_valid_next = em_valid_reg;
        k_next        = k_reg;
        addr_next     = addr_reg;
        rem_next      = rem_reg;
        if (cmd_take)
        begin
            em_valid_next = cmd_valid;
            k_next        = '0;
            addr_next     = cmd.buffer_address;
            rem_next      = REM_W'(cmd.count);
        end
        else if (fire)
        begin
            k_next = k_reg + K_W'(1);
            if (k_reg != '0)
            begin
                addr_next = addr_reg + CHUNK_BYTES;
                rem_next  = rem_reg - REM_W'(SECTORS_PER_ENTRY);
            end
        end
    end

    // Form the record for the output register
    always_comb
    begin
        rsp_valid_next = out_free ? fire : rsp_valid_reg;
        status_next    = em_cmd_reg.status;
        kind_next      = REC_HEADER;
        slot_next      = '0;
        write_next     = 1'b0;
        opcode_next    = '0;
        entries_next   = '0;
        lba_next       = '0;
        count_next     = '0;
        eaddr_next     = '0;
        ebytes_next    = '0;
        last_next      = rec_last;
        if (is_ok)
        begin
            slot_next    = em_cmd_reg.slot;
            write_next   = em_cmd_reg.write_flag;
            opcode_next  = em_cmd_reg.write_flag ? OP_WRITE_DMA_EXT : OP_READ_DMA_EXT;
            entries_next = em_cmd_reg.entry_count;
            lba_next     = em_cmd_reg.lba;
            count_next   = em_cmd_reg.count;
            if (k_reg != '0)
            begin
                kind_next   = REC_PRD;
                eaddr_next  = addr_reg;
                ebytes_next = BYTES_W'(sec_bytes);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg  <= 1'b0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            em_valid_reg  <= em_valid_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: capture on load or fire, hold otherwise
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        rem_reg  <= rem_next;
        if (load)
        begin
            em_cmd_reg <= cmd;
        end
        if (fire)
        begin
            status_reg  <= status_next;
            kind_reg    <= kind_next;
            slot_reg    <= slot_next;
            write_reg   <= write_next;
            opcode_reg  <= opcode_next;
            entries_reg <= entries_next;
            lba_reg     <= lba_next;
            count_reg   <= count_next;
            eaddr_reg   <= eaddr_next;
            ebytes_reg  <= ebytes_next;
            last_reg    <= last_next;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign record_kind      = kind_reg;
    assign slot             = slot_reg;
    assign write_flag       = write_reg;
    assign ata_opcode       = opcode_reg;
    assign entry_count      = entries_reg;
    assign lba_out          = lba_reg;
    assign count_out        = count_reg;
    assign entry_address    = eaddr_reg;
    assign entry_byte_count = ebytes_reg;
    assign last             = last_reg;

    // A rejected command never gets past its single record
    a_reject_one_record: assert property (@(posedge clk) disable iff (!rst_n)
        (em_valid_reg && !is_ok) |-> (k_reg == '0))
        else $error("rejected command stepped beyond its status record");

    // The record counter stays within the command's entry count
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (em_valid_reg && is_ok) |-> (k_reg <= em_cmd_reg.entry_count[K_W-1:0]))
        else $error("record counter ran past the entry count");

    // A command is held until its last record has gone out
    a_hold_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !rec_last) |=> em_valid_reg)
        else $error("command dropped before its last record");

    // Status records are single headers that close the transaction
    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg != ST_OK)) |-> (last_reg && (kind_reg == REC_HEADER)))
        else $error("rejection record is not a closing header");

endmodule

// ===== hdl/ahci_command_descriptor_builder.sv =====
// An accepted request moves through front stages A and B and the emitter's command
// register into the output register. Throughput: one result record per cycle at the
// output register while rsp_stall is low; a request gives entry_count + 1 records (one
// when rejected), so up to 9. Two more requests are taken while one is emitting.
// Reset (rst_n, asynchronous, active low) clears the valid bits and record counter only.
module ahci_command_descriptor_builder
    import acdb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [CMD_W-1:0]     command,
    input  logic [LBA_W-1:0]     lba,
    input  logic [COUNT_W-1:0]   sector_count,
    input  logic [ADDR_W-1:0]    buffer_address,
    input  logic [BUSY_W-1:0]    busy_slots,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [1:0]           status,
    output logic                 record_kind,
    output logic [SLOT_W-1:0]    slot,
    output logic                 write_flag,
    output logic [OPCODE_W-1:0]  ata_opcode,
    output logic [ENTRY_W-1:0]   entry_count,
    output logic [LBA_W-1:0]     lba_out,
    output logic [COUNT_W-1:0]   count_out,
    output logic [ADDR_W-1:0]    entry_address,
    output logic [BYTES_W-1:0]   entry_byte_count,
    output logic                 last
);

    request_t request;
    cmd_t     cmd;
    logic     cmd_valid;
    logic     cmd_take;

    // Gather the request fields
    assign request.command        = command;
    assign request.lba            = lba;
    assign request.sector_count   = sector_count;
    assign request.buffer_address = buffer_address;
    assign request.busy_slots     = busy_slots;

    acdb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    acdb_emit u_emit (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_take         (cmd_take),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .status           (status),
        .record_kind      (record_kind),
        .slot             (slot),
        .write_flag       (write_flag),
        .ata_opcode       (ata_opcode),
        .entry_count      (entry_count),
        .lba_out          (lba_out),
        .count_out        (count_out),
        .entry_address    (entry_address),
        .entry_byte_count (entry_byte_count),
        .last             (last)
    );

endmodule
